@@ rtl/core/kv_request_framer_core_defines.svh @@
// ----------------------------------------------------------------------------
// kv_request_framer_core_defines.svh
// Assertion macros for the key-value request framer. They expand to
// concurrent assertions in simulation and to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef KV_REQUEST_FRAMER_CORE_DEFINES_SVH
`define KV_REQUEST_FRAMER_CORE_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, checked outside reset.
`define KVRF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("kvrf assertion failed");

// Next-cycle implication, checked outside reset.
`define KVRF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("kvrf assertion failed");

`else

`define KVRF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)

`define KVRF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/core/kvrf_pkg.sv @@
// ----------------------------------------------------------------------------
// kvrf_pkg
// Shared types, codes and reset values of the key-value request framer.
// ----------------------------------------------------------------------------
package kvrf_pkg;

	localparam int LENGTH_BITS_DEF = 32;
	localparam int SEEN_W          = 32;
	localparam int LEN_OUT_W       = 32;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 32;

	// Result status codes.
	localparam logic [2:0] ST_MORE      = 3'd0;
	localparam logic [2:0] ST_COMPLETE  = 3'd1;
	localparam logic [2:0] ST_UNKNOWN   = 3'd2;
	localparam logic [2:0] ST_BAD_KEY   = 3'd3;
	localparam logic [2:0] ST_EMPTY_KEY = 3'd4;
	localparam logic [2:0] ST_TOO_LONG  = 3'd5;
	localparam logic [2:0] ST_ABORTED   = 3'd6;

	// Command codes.
	localparam logic [1:0] CMD_NONE   = 2'd0;
	localparam logic [1:0] CMD_FETCH  = 2'd1;
	localparam logic [1:0] CMD_DELETE = 2'd2;
	localparam logic [1:0] CMD_STORE  = 2'd3;

	// Byte class codes.
	localparam logic [1:0] CLS_HDR  = 2'd0;
	localparam logic [1:0] CLS_KEY  = 2'd1;
	localparam logic [1:0] CLS_DATA = 2'd2;
	localparam logic [1:0] CLS_NONE = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_FETCH_OP  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STORE_OP  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DELETE_OP = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES = 2'd3;

	// Configuration reset values.
	localparam logic [7:0]  FETCH_OP_RST  = 8'd70;
	localparam logic [7:0]  STORE_OP_RST  = 8'd83;
	localparam logic [7:0]  DELETE_OP_RST = 8'd68;
	localparam logic [31:0] MAX_BYTES_RST = 32'd1048576;

	typedef struct packed {
		logic       mode;
		logic [7:0] rx_byte;
	} kvrf_in_t;

	typedef struct packed {
		logic [2:0]           status;
		logic [1:0]           command;
		logic [1:0]           byte_class;
		logic [7:0]           echo_byte;
		logic [LEN_OUT_W-1:0] key_length;
		logic [LEN_OUT_W-1:0] data_length;
	} kvrf_out_t;

	typedef struct packed {
		logic [7:0]  fetch_op;
		logic [7:0]  store_op;
		logic [7:0]  delete_op;
		logic [31:0] max_bytes;
	} kvrf_cfg_t;

endpackage

@@ rtl/core/kvrf_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// kvrf_cfg_regs
// Configuration registers: opcode values and the request size limit.
// ----------------------------------------------------------------------------
module kvrf_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [kvrf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [kvrf_pkg::CFG_DATA_W-1:0]    cfg_data,
	output kvrf_pkg::kvrf_cfg_t                cfg
);
	import kvrf_pkg::*;

	kvrf_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fetch_op  <= FETCH_OP_RST;
			cfg_q.store_op  <= STORE_OP_RST;
			cfg_q.delete_op <= DELETE_OP_RST;
			cfg_q.max_bytes <= MAX_BYTES_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FETCH_OP: begin
					cfg_q.fetch_op <= cfg_data[7:0];
				end
				CFG_STORE_OP: begin
					cfg_q.store_op <= cfg_data[7:0];
				end
				CFG_DELETE_OP: begin
					cfg_q.delete_op <= cfg_data[7:0];
				end
				CFG_MAX_BYTES: begin
					cfg_q.max_bytes <= cfg_data[31:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/core/kvrf_frame_ctl.sv @@
// ----------------------------------------------------------------------------
// kvrf_frame_ctl
// Request state and the per-item decode: opcode match, length assembly,
// key checks, completion and size limit. State advances when fire is high.
// ----------------------------------------------------------------------------
module kvrf_frame_ctl #(
	parameter int LENGTH_BITS = kvrf_pkg::LENGTH_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  kvrf_pkg::kvrf_in_t   item,
	input  kvrf_pkg::kvrf_cfg_t  cfg,
	output kvrf_pkg::kvrf_out_t  result
);
	import kvrf_pkg::*;

	localparam int TOT_W = LENGTH_BITS + 2;
	localparam int CMP_W = SEEN_W + 2;
	localparam logic [3:0] HDR_SHORT    = 4'd5;
	localparam logic [3:0] HDR_STORE    = 4'd9;
	localparam logic [3:0] KEY_LEN_LAST = 4'd4;
	localparam logic [7:0] KEY_CHAR_MIN = 8'd32;
	localparam logic [7:0] KEY_CHAR_MAX = 8'd126;
	localparam logic [7:0] CHAR_DOT     = 8'h2E;
	localparam logic [7:0] CHAR_SLASH   = 8'h2F;

	logic [1:0]             cmd_q, cmd_d;
	logic [SEEN_W-1:0]      seen_q, seen_d;
	logic [LENGTH_BITS-1:0] key_q, key_d;
	logic [LENGTH_BITS-1:0] data_q, data_d;
	logic [TOT_W-1:0]       total_q, total_d;
	logic                   bad_q, bad_d;

	logic [SEEN_W:0]        n;
	logic [SEEN_W-1:0]      p_rel;
	logic [3:0]             hdr_len;
	logic                   hdr_end;
	logic                   hdr_done;
	logic                   total_hit;
	logic                   go_idle;
	logic                   key_ok;
	logic                   max_hit;

	assign hdr_len = (cmd_q == CMD_STORE) ? HDR_STORE : HDR_SHORT;

	always_comb begin
		cmd_d     = cmd_q;
		seen_d    = seen_q;
		key_d     = key_q;
		data_d    = data_q;
		total_d   = total_q;
		bad_d     = bad_q;
		hdr_end   = 1'b0;
		hdr_done  = 1'b0;
		total_hit = 1'b0;
		go_idle   = 1'b0;
		n         = {1'b0, seen_q} + (SEEN_W + 1)'(1);
		p_rel     = seen_q - SEEN_W'(hdr_len);
		key_ok    = (item.rx_byte inside {[KEY_CHAR_MIN:KEY_CHAR_MAX]})
		            && (item.rx_byte != CHAR_DOT) && (item.rx_byte != CHAR_SLASH);
		max_hit   = 1'b0;

		result.status      = ST_MORE;
		result.command     = cmd_q;
		result.byte_class  = CLS_HDR;
		result.echo_byte   = item.rx_byte;
		result.key_length  = '0;
		result.data_length = '0;

		if (item.mode) begin
			// Abort reports what has been decoded so far and drops the request.
			result.status     = ST_ABORTED;
			result.byte_class = CLS_NONE;
			result.echo_byte  = '0;
			if ((cmd_q != CMD_NONE) && (seen_q >= SEEN_W'(hdr_len))) begin
				result.key_length = LEN_OUT_W'(key_q);
				if (cmd_q == CMD_STORE) begin
					result.data_length = LEN_OUT_W'(data_q);
				end
			end
			go_idle = 1'b1;
		end else if (cmd_q == CMD_NONE) begin
			// Opcode byte; fetch wins over delete, delete over store.
			if (item.rx_byte == cfg.fetch_op) begin
				cmd_d = CMD_FETCH;
			end else if (item.rx_byte == cfg.delete_op) begin
				cmd_d = CMD_DELETE;
			end else if (item.rx_byte == cfg.store_op) begin
				cmd_d = CMD_STORE;
			end
			n              = (SEEN_W + 1)'(1);
			seen_d         = SEEN_W'(1);
			max_hit        = n >= (SEEN_W + 1)'(cfg.max_bytes);
			result.command = cmd_d;
			if (cmd_d == CMD_NONE) begin
				result.status = ST_UNKNOWN;
				go_idle       = 1'b1;
			end else if (max_hit) begin
				result.status = ST_TOO_LONG;
				go_idle       = 1'b1;
			end
		end else begin
			if (seen_q < SEEN_W'(hdr_len)) begin
				if (seen_q <= SEEN_W'(KEY_LEN_LAST)) begin
					key_d = {key_q[LENGTH_BITS-9:0], item.rx_byte};
				end else begin
					data_d = {data_q[LENGTH_BITS-9:0], item.rx_byte};
				end
				if (n == (SEEN_W + 1)'(hdr_len)) begin
					hdr_end = 1'b1;
					if (cmd_q != CMD_STORE) begin
						data_d = '0;
					end
					total_d = TOT_W'(hdr_len) + TOT_W'(key_d) + TOT_W'(data_d);
				end
			end else if (p_rel < SEEN_W'(key_q)) begin
				result.byte_class = CLS_KEY;
				if (!key_ok) begin
					bad_d = 1'b1;
				end
			end else begin
				result.byte_class = CLS_DATA;
			end
			seen_d   = n[SEEN_W-1:0];
			hdr_done = n >= (SEEN_W + 1)'(hdr_len);
			max_hit  = n >= (SEEN_W + 1)'(cfg.max_bytes);
			// On the last header byte the total equals the byte count exactly
			// when both lengths are zero, so the fresh sum is not compared.
			if (hdr_end) begin
				total_hit = (key_d == '0) && (data_d == '0);
			end else begin
				total_hit = CMP_W'(n) == CMP_W'(total_q);
			end
			if (hdr_done && total_hit) begin
				if (key_d == '0) begin
					result.status = ST_EMPTY_KEY;
				end else if (bad_d) begin
					result.status = ST_BAD_KEY;
				end else begin
					result.status = ST_COMPLETE;
				end
			end else if (max_hit) begin
				result.status = ST_TOO_LONG;
			end
			if (hdr_done) begin
				result.key_length = LEN_OUT_W'(key_d);
				if (cmd_q == CMD_STORE) begin
					result.data_length = LEN_OUT_W'(data_d);
				end
			end
			if (result.status != ST_MORE) begin
				go_idle = 1'b1;
			end
		end

		if (go_idle) begin
			cmd_d   = CMD_NONE;
			seen_d  = '0;
			key_d   = '0;
			data_d  = '0;
			total_d = '0;
			bad_d   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q   <= CMD_NONE;
			seen_q  <= '0;
			key_q   <= '0;
			data_q  <= '0;
			total_q <= '0;
			bad_q   <= 1'b0;
		end else if (fire) begin
			cmd_q   <= cmd_d;
			seen_q  <= seen_d;
			key_q   <= key_d;
			data_q  <= data_d;
			total_q <= total_d;
			bad_q   <= bad_d;
		end
	end

endmodule

@@ rtl/core/kv_request_framer_core.sv @@
// ----------------------------------------------------------------------------
// kv_request_framer_core
// An accepted item is held in the input register, decoded against the
// request state, and its result is captured in the output register.
// Throughput: one item per cycle while the output side does not stall, set
// by the single decode step between the input and output registers.
// Reset: arst_n clears the valid flags and the request state and returns
// the config to its reset values.
// ----------------------------------------------------------------------------
`include "kv_request_framer_core_defines.svh"

// The framer takes one request byte (or an abort event) per item and returns
// exactly one result item per input item. The datapath is two registers
// deep: an input register (_s1) holds the accepted item, and the decode
// logic in kvrf_frame_ctl turns it into a result while updating the request
// state. The result lands in the output register, which holds it while the
// downstream side stalls. The input side only stalls when the input register
// is full and cannot drain because the output register is full and stalled,
// so with no downstream backpressure a new item enters every cycle.
//
// Configuration is kept in kvrf_cfg_regs and is read directly by the decode
// logic. Writes are expected only while no item is in flight.
module kv_request_framer_core #(
	parameter int LENGTH_BITS = kvrf_pkg::LENGTH_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,

	// Input item channel.
	input  logic                              in_valid,
	output logic                              in_stall,
	input  kvrf_pkg::kvrf_in_t                in_data,

	// Result item channel.
	output logic                              out_valid,
	input  logic                              out_stall,
	output kvrf_pkg::kvrf_out_t               out_data,

	// Configuration write port.
	input  logic                              cfg_we,
	input  logic [kvrf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [kvrf_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import kvrf_pkg::*;

	kvrf_cfg_t cfg;

	// Input register.
	logic      in_valid_s1;
	kvrf_in_t  in_data_s1;

	// Output register.
	logic      out_valid_q;
	kvrf_out_t out_data_q;

	kvrf_out_t result;
	logic      advance;

	// The item in the input register moves on whenever the output register
	// is empty or is being emptied in this same cycle.
	assign advance  = in_valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = in_valid_s1 && out_valid_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			in_data_s1 <= in_data;
		end
	end

	kvrf_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Decode and request state; the state only steps when the item advances,
	// so a stalled item is decoded against the same state until it leaves.
	kvrf_frame_ctl #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_frame_ctl (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (in_data_s1),
		.cfg    (cfg),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// An item that leaves the input register always shows up as a result.
	`KVRF_ASSERT_NEXT(a_advance_to_out, clk, arst_n, advance, out_valid_q)

	// Only an unknown opcode or an abort can report no command.
	`KVRF_ASSERT_IMPL(a_none_cmd_status, clk, arst_n, out_valid_q && (out_data_q.command == CMD_NONE), (out_data_q.status == ST_UNKNOWN) || (out_data_q.status == ST_ABORTED))

	// A key byte can only be seen once a nonzero key length has been decoded.
	`KVRF_ASSERT_IMPL(a_key_needs_len, clk, arst_n, out_valid_q && (out_data_q.byte_class == CLS_KEY), out_data_q.key_length != '0)

	// Only store requests carry a data length.
	`KVRF_ASSERT_IMPL(a_data_len_store, clk, arst_n, out_valid_q && (out_data_q.data_length != '0), out_data_q.command == CMD_STORE)

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for kv_request_framer_core. Request bytes and abort
// events are queued by the stimulus process and fed to the framer by a
// clocked driver. Each accepted item runs through a behavioral model of the
// framer, and a clocked monitor compares every result item against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

	import kvrf_pkg::*;

	// Header lengths in bytes: opcode plus one or two 32-bit length words.
	localparam int HDR_SHORT = 5;
	localparam int HDR_STORE = 9;

	// Byte position of the last key-length byte within the header.
	localparam int KEYLEN_LAST_POS = 4;

	// Characters that are never allowed in a key, and the printable range.
	localparam logic [7:0] KEY_CHAR_MIN = 8'd32;
	localparam logic [7:0] KEY_CHAR_MAX = 8'd126;
	localparam logic [7:0] DOT_CHAR     = 8'h2E;
	localparam logic [7:0] SLASH_CHAR   = 8'h2F;

	// Decoded lengths keep only their low LENGTH_BITS bits.
	localparam logic [31:0] LEN_MASK = 32'((64'd1 << LENGTH_BITS_DEF) - 64'd1);

	// Queued items of random traffic per configuration phase, and the number of phases.
	localparam int PHASE_ITEMS = 28;
	localparam int NUM_PHASES  = 12;

	// Cycles without any accepted item after which the run is declared hung.
	localparam int STALL_LIMIT = 4000;

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	kvrf_in_t    in_data  = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	kvrf_out_t   out_data;
	logic        cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// Items waiting to be offered to the framer, and results it still owes.
	kvrf_in_t  rx_items[$];
	kvrf_out_t frame_results[$];

	// Percent chance per cycle that the sender holds back or the receiver
	// stalls.
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	int mismatches = 0;
	int idle_cycles = 0;

	// Model copy of the configuration registers.
	logic [7:0]  cfg_fetch_op  = FETCH_OP_RST;
	logic [7:0]  cfg_store_op  = STORE_OP_RST;
	logic [7:0]  cfg_delete_op = DELETE_OP_RST;
	logic [31:0] cfg_max_bytes = MAX_BYTES_RST;

	// Model copy of the request state.
	logic [1:0]  req_cmd      = CMD_NONE;
	logic [31:0] req_seen     = '0;
	logic [31:0] req_key_len  = '0;
	logic [31:0] req_data_len = '0;
	logic [33:0] req_total    = '0;
	logic        req_key_bad  = 1'b0;

	kv_request_framer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Every terminal status drops the request and returns to the idle state.
	function automatic void clear_request();
		req_cmd      = CMD_NONE;
		req_seen     = '0;
		req_key_len  = '0;
		req_data_len = '0;
		req_total    = '0;
		req_key_bad  = 1'b0;
	endfunction

	// Advances the request model by one item and returns the status item
	// the framer must report for it.
	function automatic kvrf_out_t frame_step(kvrf_in_t item);
		kvrf_out_t  r;
		logic [63:0] pos;
		logic [63:0] nxt;
		logic [63:0] hdr;
		logic        hdr_done;
		logic [7:0]  b;

		b            = item.rx_byte;
		r.status     = ST_MORE;
		r.command    = CMD_NONE;
		r.byte_class = CLS_HDR;
		r.echo_byte  = b;

		// An abort reports what is known of the request so far, even when
		// nothing is in progress.
		if (item.mode) begin
			hdr = (req_cmd == CMD_STORE) ? 64'(HDR_STORE) : 64'(HDR_SHORT);
			hdr_done = (req_cmd != CMD_NONE) && (64'(req_seen) >= hdr);
			r.status      = ST_ABORTED;
			r.command     = req_cmd;
			r.byte_class  = CLS_NONE;
			r.echo_byte   = 8'd0;
			r.key_length  = hdr_done ? req_key_len : '0;
			r.data_length = (hdr_done && req_cmd == CMD_STORE) ? req_data_len : '0;
			clear_request();
			return r;
		end

		pos = 64'(req_seen);
		nxt = pos + 64'd1;

		if (req_cmd == CMD_NONE) begin
			// Opcode byte: fetch has priority over delete, delete over store.
			if (b == cfg_fetch_op)
				req_cmd = CMD_FETCH;
			else if (b == cfg_delete_op)
				req_cmd = CMD_DELETE;
			else if (b == cfg_store_op)
				req_cmd = CMD_STORE;
			if (req_cmd == CMD_NONE) begin
				r.status      = ST_UNKNOWN;
				r.key_length  = '0;
				r.data_length = '0;
				clear_request();
				return r;
			end
			pos      = 64'd0;
			nxt      = 64'd1;
			req_seen = 32'd1;
		end else begin
			hdr = (req_cmd == CMD_STORE) ? 64'(HDR_STORE) : 64'(HDR_SHORT);
			if (pos < hdr) begin
				// Big-endian length words; the total is formed on the last one.
				if (pos <= KEYLEN_LAST_POS)
					req_key_len = {req_key_len[23:0], b};
				else
					req_data_len = {req_data_len[23:0], b};
				if (nxt == hdr) begin
					req_key_len  = req_key_len & LEN_MASK;
					req_data_len = (req_cmd == CMD_STORE) ? (req_data_len & LEN_MASK) : '0;
					req_total    = 34'(hdr) + 34'(req_key_len) + 34'(req_data_len);
				end
			end else if (pos - hdr < 64'(req_key_len)) begin
				r.byte_class = CLS_KEY;
				if (b < KEY_CHAR_MIN || b > KEY_CHAR_MAX || b == DOT_CHAR || b == SLASH_CHAR)
					req_key_bad = 1'b1;
			end else begin
				r.byte_class = CLS_DATA;
			end
			req_seen = nxt[31:0];
		end

		hdr      = (req_cmd == CMD_STORE) ? 64'(HDR_STORE) : 64'(HDR_SHORT);
		hdr_done = nxt >= hdr;

		// Completion wins over the size limit when both hit on one byte.
		if (hdr_done && nxt == 64'(req_total)) begin
			if (req_key_len == 32'd0)
				r.status = ST_EMPTY_KEY;
			else if (req_key_bad)
				r.status = ST_BAD_KEY;
			else
				r.status = ST_COMPLETE;
		end else if (nxt >= 64'(cfg_max_bytes)) begin
			r.status = ST_TOO_LONG;
		end

		r.command     = req_cmd;
		r.key_length  = hdr_done ? req_key_len : '0;
		r.data_length = (hdr_done && req_cmd == CMD_STORE) ? req_data_len : '0;
		if (r.status != ST_MORE)
			clear_request();
		return r;
	endfunction

	// Driver: offers the next queued item whenever the slot is free. A held
	// item stays on the bus unchanged until the framer takes it, and each
	// accepted item is run through the model at the edge that takes it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
		end else begin
			if (in_valid && !in_stall)
				frame_results.push_back(frame_step(in_data));
			if (!in_valid || !in_stall) begin
				if (rx_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_data  <= rx_items.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	// Monitor: every accepted result item is matched against the oldest
	// outstanding prediction. The stall is redrawn every cycle, independent
	// of whether a result is present.
	always @(posedge clk or negedge arst_n) begin
		kvrf_out_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (frame_results.size() == 0) begin
					$error("result item with no prediction outstanding: %h", out_data);
					mismatches++;
				end else begin
					want = frame_results.pop_front();
					check_field("status", 32'(want.status), 32'(out_data.status));
					check_field("command", 32'(want.command), 32'(out_data.command));
					check_field("byte_class", 32'(want.byte_class), 32'(out_data.byte_class));
					check_field("echo_byte", 32'(want.echo_byte), 32'(out_data.echo_byte));
					check_field("key_length", want.key_length, out_data.key_length);
					check_field("data_length", want.data_length, out_data.data_length);
				end
			end
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// Watchdog: a run that accepts nothing on either channel for too long
	// is hung.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else if (idle_cycles >= STALL_LIMIT) begin
			$error("no item accepted for %0d cycles", STALL_LIMIT);
			$display("FAIL");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	task automatic push_byte(logic [7:0] b);
		kvrf_in_t item;
		item.mode    = 1'b0;
		item.rx_byte = b;
		rx_items.push_back(item);
	endtask

	// The byte lane of an abort is ignored, so it carries random content.
	task automatic push_abort();
		kvrf_in_t item;
		item.mode    = 1'b1;
		item.rx_byte = 8'($urandom_range(0, 255));
		rx_items.push_back(item);
	endtask

	task automatic push_word(logic [31:0] w);
		push_byte(w[31:24]);
		push_byte(w[23:16]);
		push_byte(w[15:8]);
		push_byte(w[7:0]);
	endtask

	// Sampled on the falling edge so that driver and monitor updates of the
	// rising edge have settled: nothing queued, nothing offered, nothing owed.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (rx_items.size() != 0 || in_valid || frame_results.size() != 0);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
	endtask

	// Writes all four registers back to back; called only while drained.
	task automatic write_config(logic [7:0] f, logic [7:0] s, logic [7:0] d, logic [31:0] m);
		cfg_fetch_op  = f;
		cfg_store_op  = s;
		cfg_delete_op = d;
		cfg_max_bytes = m;
		write_reg(CFG_FETCH_OP, {24'd0, f});
		write_reg(CFG_STORE_OP, {24'd0, s});
		write_reg(CFG_DELETE_OP, {24'd0, d});
		write_reg(CFG_MAX_BYTES, m);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Queues one random unit of traffic. Most units are well-formed requests
	// with random content; the rest are stray bytes, aborts, and requests
	// that are cut short or lose their last byte.
	task automatic queue_request();
		int          kind;
		int          sel;
		int          n_body;
		int          abort_at;
		logic [7:0]  c;
		logic [31:0] klen;
		logic [31:0] dlen;
		logic [63:0] body_len;
		bit          to_store;
		logic [7:0]  frame[$];

		kind = $urandom_range(0, 99);
		if (kind < 8) begin
			push_byte(8'($urandom_range(0, 255)));
		end else if (kind < 13) begin
			push_abort();
		end else begin
			sel      = $urandom_range(0, 2);
			to_store = (sel == 2);
			frame.push_back((sel == 0) ? cfg_fetch_op : (sel == 1) ? cfg_delete_op : cfg_store_op);
			if (kind < 85) begin
				klen = $urandom_range(0, 6);
				dlen = $urandom_range(0, 6);
			end else begin
				// Huge lengths exercise the upper length bits; such requests
				// end in too long or are aborted after a few body bytes.
				klen = $urandom();
				dlen = $urandom();
				if ($urandom_range(0, 1))
					klen = $urandom_range(0, 3);
			end
			for (int i = 3; i >= 0; i--)
				frame.push_back(klen[i*8 +: 8]);
			if (to_store)
				for (int i = 3; i >= 0; i--)
					frame.push_back(dlen[i*8 +: 8]);

			body_len = 64'(klen) + (to_store ? 64'(dlen) : 64'd0);
			n_body = (body_len > 64'd12) ? $urandom_range(0, 6) : int'(body_len);
			for (int i = 0; i < n_body; i++) begin
				if (64'(i) < 64'(klen) && $urandom_range(0, 9) != 0) begin
					c = 8'($urandom_range(KEY_CHAR_MIN, KEY_CHAR_MAX));
					if (c == DOT_CHAR || c == SLASH_CHAR)
						c = c + 8'd2;
				end else begin
					c = 8'($urandom_range(0, 255));
				end
				frame.push_back(c);
			end

			abort_at = -1;
			if (body_len > 64'd12)
				abort_at = frame.size();
			else if ($urandom_range(0, 9) == 0)
				abort_at = $urandom_range(1, frame.size() - 1);
			else if ($urandom_range(0, 19) == 0)
				void'(frame.pop_back());

			foreach (frame[i])
				if (abort_at < 0 || i < abort_at)
					push_byte(frame[i]);
			if (abort_at >= 0)
				push_abort();
		end
	endtask

	// Stimulus: a directed run at the reset configuration, then one phase of
	// random traffic per configuration setting, each on a drained framer.
	initial begin
		logic [7:0]  f;
		logic [7:0]  s;
		logic [7:0]  d;
		logic [31:0] m;
		int          start;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 33;
		recv_idle_pct = 52;

		// Abort with nothing in progress, then an unknown opcode.
		push_abort();
		push_byte(8'hFF);
		// Fetch with an empty key ends on its last header byte.
		push_byte(FETCH_OP_RST);
		push_word(32'd0);
		// Delete with a one-byte key at the top of the printable range.
		push_byte(DELETE_OP_RST);
		push_word(32'd1);
		push_byte(KEY_CHAR_MAX);
		// Store whose key byte is just above the printable range.
		push_byte(STORE_OP_RST);
		push_word(32'd1);
		push_word(32'd1);
		push_byte(KEY_CHAR_MAX + 8'd1);
		push_byte(8'h00);
		wait_drained();

		for (int k = 0; k < NUM_PHASES; k++) begin
			// The sender/receiver idle mix changes with the phase number.
			if (k < 4) begin
				send_idle_pct = 33;
				recv_idle_pct = 52;
			end else if (k < 8) begin
				send_idle_pct = 52;
				recv_idle_pct = 33;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end

			f = 8'($urandom_range(0, 255));
			s = 8'($urandom_range(0, 255));
			d = 8'($urandom_range(0, 255));
			case (k % 6)
				0: m = $urandom_range(5, 40);
				1: begin
					// All opcodes equal: fetch must win.
					f = 8'h00;
					s = 8'h00;
					d = 8'h00;
					m = 32'hFFFF_FFFF;
				end
				2: begin
					f = 8'hFF;
					s = 8'hFF;
					d = 8'hFF;
					m = 32'd1;
				end
				3: begin
					d = f;
					m = $urandom_range(2, 4);
				end
				4: begin
					f = FETCH_OP_RST;
					d = s;
					m = MAX_BYTES_RST;
				end
				default: m = $urandom_range(6, 20);
			endcase
			write_config(f, s, d, m);

			start = rx_items.size();
			while (rx_items.size() - start < PHASE_ITEMS / 2)
				queue_request();
			// In phase 5 only, the sender waits mid-phase until every result is back.
			if (k == 5)
				wait_drained();
			start = rx_items.size() - PHASE_ITEMS / 2;
			while (rx_items.size() - start < PHASE_ITEMS)
				queue_request();
			// Leave the framer idle before the next setting.
			push_abort();
			wait_drained();
		end

		// Let any stray result surface before the final verdict.
		repeat (4) @(posedge clk);
		if (frame_results.size() != 0) begin
			$error("%0d predicted results never arrived", frame_results.size());
			mismatches++;
		end

		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ kv_request_framer_core.f @@
+incdir+rtl/core
rtl/core/kvrf_pkg.sv
rtl/core/kvrf_cfg_regs.sv
rtl/core/kvrf_frame_ctl.sv
rtl/core/kv_request_framer_core.sv
verif/testbench.sv
